/* hw/rtl/swa_pkg.sv */
// ----------------------------------------------------------------------------
// swa_pkg: shared types and constants of the stopwatch with temperature alarm
// Item kinds, register indexes, field widths and the counter cell control.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int KIND_W   = 3;
    localparam int TEMP_W   = 12;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int DIGIT_W  = 4;
    localparam int GROUP_W  = 3 * DIGIT_W;

    // item kinds carried in the input word's tuser
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PAUSE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RESUME = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_HALF_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH_DIVIDER  = 2'd2;

    localparam logic [TEMP_W-1:0] THRESHOLD_RESET   = 12'd480;
    localparam logic [7:0]        HALF_PERIOD_RESET = 8'd5;
    localparam logic [7:0]        DIVIDER_RESET     = 8'd10;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    // control handed to a counter cell or a group of cells
    typedef struct packed {
        logic en;    // the word is accepted, commit the next value
        logic inc;   // count up by one
        logic zero;  // force to zero (clear key or wrap of the group)
    } cnt_ctrl_t;

endpackage

/* hw/rtl/stopwatch_with_temperature_alarm_core.sv */
// ----------------------------------------------------------------------------
// stopwatch_with_temperature_alarm_core: mm:ss.cc stopwatch with buzzer
// Decimal counter cells for the elapsed time, refresh and buzzer control.
// ----------------------------------------------------------------------------
// Input channel s_*: one word per event. s_tuser carries the kind (tick,
// pause, resume, clear, temperature sample), s_tdata the signed sample.
// Result channel m_*: exactly one word per input word, with the six time
// digits, the running flag, the active-low buzzer level and the refresh flag,
// all as they stand after the event.
// The result is written to the output register at the edge that takes the input
// word. One word is accepted every cycle while the receiver keeps up; the single
// output register sets that figure, and s_tready stays high while that register is
// empty or being read in the same cycle.
// When the receiver stalls, the result holds and s_tready drops until it is
// taken; no state changes meanwhile.
// Reset (aresetn low, synchronous) clears the time to 00:00.00 with the
// stopwatch running, silences the buzzer, empties the output register and
// loads the registers with threshold 480, half period 5 and divider 10.
// The cfg_* port writes a register at any edge with cfg_wr_en high.
// ----------------------------------------------------------------------------
module stopwatch_with_temperature_alarm_core
    import swa_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 100,
    parameter int MINUTE_LIMIT     = 100
)(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // temp_sample[11:0]
    input  logic [KIND_W-1:0]    s_tuser,   // kind[2:0]
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // minute_tens[3:0], minute_ones[7:4], second_tens[10:8], second_ones[14:11],
    // centi_tens[18:15], centi_ones[22:19], is_running[23], buzzer_pin[24],
    // refresh[25]
    output logic [31:0]          m_tdata,
    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int SUB_MAX = TICKS_PER_SECOND - 1;
    localparam int MIN_MAX = MINUTE_LIMIT - 1;
    localparam logic [11:0] SUB_MAX_BCD = {4'((SUB_MAX / 100) % 10),
                                           4'((SUB_MAX / 10) % 10),
                                           4'(SUB_MAX % 10)};
    localparam logic [11:0] SEC_MAX_BCD = 12'h059;
    localparam logic [11:0] MIN_MAX_BCD = {4'((MIN_MAX / 100) % 10),
                                           4'((MIN_MAX / 10) % 10),
                                           4'(MIN_MAX % 10)};
    localparam int COUNT_W = 3 * GROUP_W;

    logic              accept;
    logic              is_tick;
    logic              is_clear;

    logic [TEMP_W-1:0] threshold_reg;
    logic [7:0]        half_period_reg;
    logic [7:0]        divider_reg;

    logic              running_reg, running_next;
    logic [7:0]        refresh_cnt_reg, refresh_cnt_next;
    logic [COUNT_W-1:0] shown_reg, shown_next;
    logic              alarm_reg, alarm_next;
    logic [7:0]        beep_cnt_reg, beep_cnt_next;
    logic              phase_reg, phase_next;
    logic              buzzer_reg, buzzer_next;
    logic              refresh_reg, refresh_next;
    logic              m_valid_reg;

    cnt_ctrl_t          sub_ctrl, sec_ctrl, min_ctrl;
    logic [GROUP_W-1:0] sub_digits, sec_digits, min_digits;
    logic [GROUP_W-1:0] sub_digits_next, sec_digits_next, min_digits_next;
    logic               sub_wrap, sec_wrap;
    logic [COUNT_W-1:0] count, count_next;

    logic [7:0]        refresh_cnt_inc, beep_cnt_inc;
    logic [7:0]        divider_eff, half_period_eff;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_tick  = (s_tuser == KIND_TICK);
    assign is_clear = (s_tuser == KIND_CLEAR);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg   <= THRESHOLD_RESET;
            half_period_reg <= HALF_PERIOD_RESET;
            divider_reg     <= DIVIDER_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ALARM_THRESHOLD:  threshold_reg   <= cfg_data;
                REG_BEEP_HALF_PERIOD: half_period_reg <= cfg_data[7:0];
                REG_REFRESH_DIVIDER:  divider_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // elapsed time as a row of decimal cells: centiseconds, seconds, minutes
    assign sub_ctrl = '{en: accept, inc: is_tick && running_reg, zero: is_clear};
    assign sec_ctrl = '{en: accept, inc: sub_wrap, zero: is_clear};
    assign min_ctrl = '{en: accept, inc: sec_wrap, zero: is_clear};

    swa_group #(.MAX_BCD(SUB_MAX_BCD)) u_sub (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (sub_ctrl),
        .digits      (sub_digits),
        .digits_next (sub_digits_next),
        .wrap        (sub_wrap)
    );

    swa_group #(.MAX_BCD(SEC_MAX_BCD)) u_sec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (sec_ctrl),
        .digits      (sec_digits),
        .digits_next (sec_digits_next),
        .wrap        (sec_wrap)
    );

    swa_group #(.MAX_BCD(MIN_MAX_BCD)) u_min (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (min_ctrl),
        .digits      (min_digits),
        .digits_next (min_digits_next),
        .wrap        ()
    );

    assign count      = {min_digits, sec_digits, sub_digits};
    assign count_next = {min_digits_next, sec_digits_next, sub_digits_next};

    assign divider_eff     = (divider_reg == 8'd0) ? 8'd1 : divider_reg;
    assign half_period_eff = (half_period_reg == 8'd0) ? 8'd1 : half_period_reg;
    assign refresh_cnt_inc = refresh_cnt_reg + 8'd1;
    assign beep_cnt_inc    = beep_cnt_reg + 8'd1;

    always_comb begin
        running_next     = running_reg;
        refresh_cnt_next = refresh_cnt_reg;
        shown_next       = shown_reg;
        alarm_next       = alarm_reg;
        beep_cnt_next    = beep_cnt_reg;
        phase_next       = phase_reg;
        buzzer_next      = buzzer_reg;
        refresh_next     = 1'b0;
        case (s_tuser)
            KIND_TICK: begin
                refresh_cnt_next = refresh_cnt_inc;
                if (refresh_cnt_inc >= divider_eff) begin
                    refresh_cnt_next = '0;
                    if (count_next != shown_reg) begin
                        shown_next   = count_next;
                        refresh_next = 1'b1;
                    end
                end
                if (alarm_reg) begin
                    beep_cnt_next = beep_cnt_inc;
                    if (beep_cnt_inc >= half_period_eff) begin
                        beep_cnt_next = '0;
                        phase_next    = !phase_reg;
                        buzzer_next   = !phase_reg;
                    end
                end else begin
                    beep_cnt_next = '0;
                    phase_next    = 1'b0;
                    buzzer_next   = 1'b1;
                end
            end
            KIND_PAUSE:  running_next = 1'b0;
            KIND_RESUME: running_next = 1'b1;
            KIND_CLEAR: begin
                running_next = 1'b0;
                refresh_next = 1'b1;
            end
            KIND_SAMPLE: alarm_next = $signed(s_tdata[TEMP_W-1:0]) > $signed(threshold_reg);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg     <= 1'b1;
            refresh_cnt_reg <= '0;
            shown_reg       <= '0;
            alarm_reg       <= 1'b0;
            beep_cnt_reg    <= '0;
            phase_reg       <= 1'b0;
            buzzer_reg      <= 1'b1;
            refresh_reg     <= 1'b0;
        end else if (accept) begin
            running_reg     <= running_next;
            refresh_cnt_reg <= refresh_cnt_next;
            shown_reg       <= shown_next;
            alarm_reg       <= alarm_next;
            beep_cnt_reg    <= beep_cnt_next;
            phase_reg       <= phase_next;
            buzzer_reg      <= buzzer_next;
            refresh_reg     <= refresh_next;
        end
    end

    // hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    // the state only moves on accept, so it is the result while the word waits
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0,
                       refresh_reg,
                       buzzer_reg,
                       running_reg,
                       count[3:0],
                       count[7:4],
                       count[15:12],
                       count[18:16],
                       count[27:24],
                       count[31:28]};

endmodule

/* hw/rtl/swa_digit.sv */
// ----------------------------------------------------------------------------
// swa_digit: one decimal counter cell
// Holds one digit, counts 0..9 and hands its carry to the next cell.
// ----------------------------------------------------------------------------
module swa_digit
    import swa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cnt_ctrl_t          ctrl,
    output logic [DIGIT_W-1:0] digit,
    output logic [DIGIT_W-1:0] digit_next,
    output logic               carry
);

    logic [DIGIT_W-1:0] digit_reg;

    assign digit = digit_reg;
    assign carry = ctrl.inc && (digit_reg == DIGIT_MAX);

    always_comb begin
        if (ctrl.zero) begin
            digit_next = '0;
        end else if (ctrl.inc) begin
            digit_next = (digit_reg == DIGIT_MAX) ? '0 : digit_reg + 1'b1;
        end else begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg <= '0;
        end else if (ctrl.en) begin
            digit_reg <= digit_next;
        end
    end

endmodule

/* hw/rtl/swa_group.sv */
// ----------------------------------------------------------------------------
// swa_group: three-digit counter of one time unit
// Chains three digit cells and wraps to zero after the value MAX_BCD.
// ----------------------------------------------------------------------------
module swa_group
    import swa_pkg::*;
#(
    parameter logic [11:0] MAX_BCD = 12'h099
)(
    input  logic               aclk,
    input  logic               aresetn,
    input  cnt_ctrl_t          ctrl,
    output logic [GROUP_W-1:0] digits,
    output logic [GROUP_W-1:0] digits_next,
    output logic               wrap
);

    cnt_ctrl_t   cell_ctrl [3];
    logic [2:0]  carry;
    logic        zero;

    // wrap when the last value of the unit is passed
    assign wrap = ctrl.inc && (digits == MAX_BCD);
    assign zero = ctrl.zero || wrap;

    for (genvar i = 0; i < 3; i++) begin : g_cell
        assign cell_ctrl[i].en   = ctrl.en;
        assign cell_ctrl[i].zero = zero;
        if (i == 0) begin : g_first
            assign cell_ctrl[i].inc = ctrl.inc;
        end else begin : g_rest
            assign cell_ctrl[i].inc = carry[i-1];
        end

        swa_digit u_digit (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl[i]),
            .digit      (digits[i*DIGIT_W +: DIGIT_W]),
            .digit_next (digits_next[i*DIGIT_W +: DIGIT_W]),
            .carry      (carry[i])
        );
    end

endmodule
